// ===== hw/rtl/peer_score_table_fifo_evict_core_defines.svh =====
// Assertion helpers shared by the score table RTL.
`ifndef PEER_SCORE_TABLE_FIFO_EVICT_CORE_DEFINES_SVH
`define PEER_SCORE_TABLE_FIFO_EVICT_CORE_DEFINES_SVH

// Check that cond holds in the same cycle whenever trig holds.
`define PSTFE_ASSERT_IMPL(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define PSTFE_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/pstfe_pkg.sv =====
`timescale 1ns / 1ps

package pstfe_pkg;

  localparam int KEY_W     = 64;
  localparam int SCORE_W   = 17;
  localparam int DELTA_W   = 18;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam int ENTRIES_DEF = 64;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 18'sd65536;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = -18'sd65536;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGFAIL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUSTODY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIV_OK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIV_BAD = 3'd5;

  // Register reset values
  localparam logic signed [DELTA_W-1:0] FLOOD_RST     = -18'sd3277;
  localparam logic signed [DELTA_W-1:0] REPLAY_RST    = -18'sd9830;
  localparam logic signed [DELTA_W-1:0] SIGFAIL_RST   = -18'sd13107;
  localparam logic signed [DELTA_W-1:0] CUSTODY_RST   = -18'sd3277;
  localparam logic signed [DELTA_W-1:0] DELIV_OK_RST  = 18'sd655;
  localparam logic signed [DELTA_W-1:0] DELIV_BAD_RST = -18'sd1311;

  typedef enum logic [KIND_W-1:0] {
    KIND_FLOOD     = 3'd0,
    KIND_REPLAY    = 3'd1,
    KIND_SIGFAIL   = 3'd2,
    KIND_CUSTODY   = 3'd3,
    KIND_DELIV_OK  = 3'd4,
    KIND_DELIV_BAD = 3'd5,
    KIND_WEIGHTED  = 3'd6,
    KIND_QUERY     = 3'd7
  } kind_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] flood;
    logic signed [DELTA_W-1:0] replay;
    logic signed [DELTA_W-1:0] sigfail;
    logic signed [DELTA_W-1:0] custody;
    logic signed [DELTA_W-1:0] deliv_ok;
    logic signed [DELTA_W-1:0] deliv_bad;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SREAD,
    ST_MISS,
    ST_CALC,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/pstfe_ram.sv =====
`timescale 1ns / 1ps

module pstfe_ram #(
  parameter int DEPTH = pstfe_pkg::ENTRIES_DEF,
  parameter int WIDTH = pstfe_pkg::KEY_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pstfe_score_alu.sv =====
`timescale 1ns / 1ps

module pstfe_score_alu (
  input  pstfe_pkg::kind_t                        kind,
  input  logic signed [pstfe_pkg::DELTA_W-1:0]    amount,
  input  pstfe_pkg::cfg_t                         cfg,
  input  logic        [pstfe_pkg::SCORE_W-1:0]    base,
  output logic        [pstfe_pkg::SCORE_W-1:0]    sum
);

  logic signed [pstfe_pkg::DELTA_W-1:0] delta;
  logic signed [pstfe_pkg::DELTA_W:0]   total;

  // Pick the delta for this event kind; saturate the weighted amount
  always_comb begin
    case (kind)
      pstfe_pkg::KIND_FLOOD:     delta = cfg.flood;
      pstfe_pkg::KIND_REPLAY:    delta = cfg.replay;
      pstfe_pkg::KIND_SIGFAIL:   delta = cfg.sigfail;
      pstfe_pkg::KIND_CUSTODY:   delta = cfg.custody;
      pstfe_pkg::KIND_DELIV_OK:  delta = cfg.deliv_ok;
      pstfe_pkg::KIND_DELIV_BAD: delta = cfg.deliv_bad;
      pstfe_pkg::KIND_WEIGHTED: begin
        if (amount < pstfe_pkg::DELTA_MIN) begin
          delta = pstfe_pkg::DELTA_MIN;
        end else if (amount > pstfe_pkg::DELTA_MAX) begin
          delta = pstfe_pkg::DELTA_MAX;
        end else begin
          delta = amount;
        end
      end
      default: delta = '0;
    endcase
  end

  // Add and clamp to [0, 1.0]
  always_comb begin
    total = $signed({2'b00, base}) + $signed({delta[pstfe_pkg::DELTA_W-1], delta});
    if (total < 0) begin
      sum = '0;
    end else if (total > $signed({2'b00, pstfe_pkg::SCORE_ONE})) begin
      sum = pstfe_pkg::SCORE_ONE;
    end else begin
      sum = total[pstfe_pkg::SCORE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/peer_score_table_fifo_evict_core.sv =====
`timescale 1ns / 1ps
`include "peer_score_table_fifo_evict_core_defines.svh"

// Peer score table with oldest-first replacement.
// Input channel (in_valid/in_ready) carries kind, peer_key and weighted_amount.
// Each word gives exactly one result word on the output channel
// (out_valid/out_ready): score in Q1.16, was_known and evicted.
// Config channel (cfg_valid/cfg_ready, always ready) writes the six delta
// registers by cfg_index; indexes above five are dropped. Write only when idle.
// The key lookup is a linear scan through the key RAM, one entry per cycle,
// using one shared comparator; the RAM read port sets the pace.
// From accept, a word passes through the scan state, then on a hit the score
// read and calculate states, on a missed event the miss and calculate states,
// on a missed query the miss state alone, and last the done state.
// in_ready is high only in the idle state, so a new word is taken only after
// the last one has been loaded into the output register.
// The output register holds a finished result while the receiver stalls;
// the next word is accepted meanwhile and completes into the output only
// after the held result is taken.
// Reset clears the entry count, the replacement pointer and the output
// valid, and loads the delta registers with their defaults. No clearing pass
// runs; the key and score RAMs are read only below the entry count.
module peer_score_table_fifo_evict_core #(
  parameter int ENTRIES = pstfe_pkg::ENTRIES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic        [pstfe_pkg::KIND_W-1:0]      kind,
  input  logic        [pstfe_pkg::KEY_W-1:0]       peer_key,
  input  logic signed [pstfe_pkg::DELTA_W-1:0]     weighted_amount,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic        [pstfe_pkg::SCORE_W-1:0]     score,
  output logic                                     was_known,
  output logic                                     evicted,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic        [pstfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic signed [pstfe_pkg::DELTA_W-1:0]     cfg_data
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  pstfe_pkg::state_t state, state_next;
  pstfe_pkg::cfg_t   cfg;

  pstfe_pkg::kind_t                      item_kind;
  logic [pstfe_pkg::KEY_W-1:0]           item_key;
  logic signed [pstfe_pkg::DELTA_W-1:0]  item_amount;
  logic [SW-1:0]                         item_slot;
  logic                                  known;

  logic [CW-1:0] entry_count;
  logic [SW-1:0] oldest_slot;
  logic [CW-1:0] scan_idx;
  logic          pend;
  logic [SW-1:0] pend_slot;

  logic [pstfe_pkg::SCORE_W-1:0] res_score;
  logic                          res_known;
  logic                          res_evict;
  logic                          res_write;

  logic                          in_take;
  logic                          scan_hit;
  logic                          scan_issue;
  logic                          table_full;
  logic [SW-1:0]                 miss_slot;
  logic                          key_we;
  logic                          score_re;
  logic                          out_load;
  logic [pstfe_pkg::KEY_W-1:0]   key_rd_data;
  logic [pstfe_pkg::SCORE_W-1:0] score_rd_data;
  logic [pstfe_pkg::SCORE_W-1:0] alu_base;
  logic [pstfe_pkg::SCORE_W-1:0] alu_sum;

  assign in_ready   = (state == pstfe_pkg::ST_IDLE);
  assign in_take    = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign table_full = (entry_count == CW'(ENTRIES));
  assign miss_slot  = table_full ? oldest_slot : entry_count[SW-1:0];
  assign alu_base   = known ? score_rd_data : pstfe_pkg::SCORE_ONE;

  // Write delta registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flood     <= pstfe_pkg::FLOOD_RST;
      cfg.replay    <= pstfe_pkg::REPLAY_RST;
      cfg.sigfail   <= pstfe_pkg::SIGFAIL_RST;
      cfg.custody   <= pstfe_pkg::CUSTODY_RST;
      cfg.deliv_ok  <= pstfe_pkg::DELIV_OK_RST;
      cfg.deliv_bad <= pstfe_pkg::DELIV_BAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pstfe_pkg::CFG_FLOOD:     cfg.flood     <= cfg_data;
        pstfe_pkg::CFG_REPLAY:    cfg.replay    <= cfg_data;
        pstfe_pkg::CFG_SIGFAIL:   cfg.sigfail   <= cfg_data;
        pstfe_pkg::CFG_CUSTODY:   cfg.custody   <= cfg_data;
        pstfe_pkg::CFG_DELIV_OK:  cfg.deliv_ok  <= cfg_data;
        pstfe_pkg::CFG_DELIV_BAD: cfg.deliv_bad <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pstfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the scan, update and result handoff
  always_comb begin
    state_next = state;
    scan_hit   = 1'b0;
    scan_issue = 1'b0;
    key_we     = 1'b0;
    score_re   = 1'b0;
    out_load   = 1'b0;
    case (state)
      pstfe_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = pstfe_pkg::ST_SCAN;
        end
      end
      pstfe_pkg::ST_SCAN: begin
        if (pend && (key_rd_data == item_key)) begin
          scan_hit   = 1'b1;
          state_next = pstfe_pkg::ST_SREAD;
        end else if (scan_idx < entry_count) begin
          scan_issue = 1'b1;
        end else if (!pend) begin
          state_next = pstfe_pkg::ST_MISS;
        end
      end
      pstfe_pkg::ST_SREAD: begin
        score_re   = 1'b1;
        state_next = pstfe_pkg::ST_CALC;
      end
      pstfe_pkg::ST_MISS: begin
        if (item_kind == pstfe_pkg::KIND_QUERY) begin
          state_next = pstfe_pkg::ST_DONE;
        end else begin
          key_we     = 1'b1;
          state_next = pstfe_pkg::ST_CALC;
        end
      end
      pstfe_pkg::ST_CALC: begin
        state_next = pstfe_pkg::ST_DONE;
      end
      pstfe_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = pstfe_pkg::ST_IDLE;
        end
      end
      default: state_next = pstfe_pkg::ST_IDLE;
    endcase
  end

  // Track table fill and the replacement pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      oldest_slot <= '0;
    end else if (key_we) begin
      if (table_full) begin
        oldest_slot <= (oldest_slot == SW'(ENTRIES - 1)) ? '0 : oldest_slot + 1'b1;
      end else begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  // Advance the scan pointer and pending-read flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_take) begin
      pend <= 1'b0;
    end else if (state == pstfe_pkg::ST_SCAN) begin
      pend <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      scan_idx <= '0;
    end else if (scan_issue) begin
      scan_idx  <= scan_idx + 1'b1;
      pend_slot <= scan_idx[SW-1:0];
    end
  end

  // Capture the word and build the result
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_kind   <= pstfe_pkg::kind_t'(kind);
      item_key    <= peer_key;
      item_amount <= weighted_amount;
    end
    if (scan_hit) begin
      item_slot <= pend_slot;
      known     <= 1'b1;
    end
    case (state)
      pstfe_pkg::ST_SREAD: begin
        res_evict <= 1'b0;
      end
      pstfe_pkg::ST_MISS: begin
        known     <= 1'b0;
        item_slot <= miss_slot;
        if (item_kind == pstfe_pkg::KIND_QUERY) begin
          res_score <= pstfe_pkg::SCORE_ONE;
          res_known <= 1'b0;
          res_evict <= 1'b0;
          res_write <= 1'b0;
        end else begin
          res_evict <= table_full;
        end
      end
      pstfe_pkg::ST_CALC: begin
        res_known <= known;
        if (item_kind == pstfe_pkg::KIND_QUERY) begin
          res_score <= score_rd_data;
          res_write <= 1'b0;
        end else begin
          res_score <= alu_sum;
          res_write <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      score     <= res_score;
      was_known <= res_known;
      evicted   <= res_evict;
    end
  end

  pstfe_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (pstfe_pkg::KEY_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (miss_slot),
    .wdata (item_key),
    .re    (scan_issue),
    .raddr (scan_idx[SW-1:0]),
    .rdata (key_rd_data)
  );

  pstfe_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (pstfe_pkg::SCORE_W)
  ) u_score_ram (
    .clk   (clk),
    .we    (out_load && res_write),
    .waddr (item_slot),
    .wdata (res_score),
    .re    (score_re),
    .raddr (item_slot),
    .rdata (score_rd_data)
  );

  pstfe_score_alu u_alu (
    .kind   (item_kind),
    .amount (item_amount),
    .cfg    (cfg),
    .base   (alu_base),
    .sum    (alu_sum)
  );

  `PSTFE_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, entry_count <= CW'(ENTRIES), "entry count overflow")
  `PSTFE_ASSERT_IMPL(a_ptr_full, clk, rst, oldest_slot != '0, table_full, "pointer moved early")
  `PSTFE_ASSERT_NEXT(a_scan_start, clk, rst, in_take, (state == pstfe_pkg::ST_SCAN) && !pend && (scan_idx == '0), "scan start")
  `PSTFE_ASSERT_IMPL(a_evict_miss, clk, rst, out_valid && evicted, !was_known, "evict on hit")

endmodule
